>>> sv/kfcv_pkg.sv
// Shared constants, types and register codes of the constant-velocity Kalman filter.
`timescale 1ns / 1ps

package kfcv_pkg;

  // Covariance entries are 48-bit signed with the same fraction bits as the data.
  localparam int COV_WIDTH  = 48;
  localparam int HALF_WIDTH = COV_WIDTH / 2;
  localparam int PROD_WIDTH = 2 * COV_WIDTH;

  localparam int DEF_DATA_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int CFG_WIDTH      = 31;
  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;

  localparam logic [CFG_WIDTH-1:0] PROCESS_NOISE_RESET     = 31'd131072;
  localparam logic [CFG_WIDTH-1:0] MEASUREMENT_NOISE_RESET = 31'd655360;

  typedef logic signed [COV_WIDTH-1:0] cov_t;

  typedef enum logic {
    REG_PROCESS_NOISE     = 1'b0,
    REG_MEASUREMENT_NOISE = 1'b1
  } kfcv_reg_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] process_noise;
    logic [CFG_WIDTH-1:0] measurement_noise;
  } kfcv_cfg_t;

  // Status of a shared arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } kfcv_unit_stat_t;

endpackage

>>> sv/kfcv_if.sv
// Valid/ready stream interfaces for the measurement and estimate channels.
`timescale 1ns / 1ps

interface kfcv_meas_if import kfcv_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface kfcv_est_if import kfcv_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] filtered_position;
  logic signed [DATA_WIDTH-1:0] filtered_velocity;

  modport source (output valid, output filtered_position, output filtered_velocity, input ready);
  modport sink   (input valid, input filtered_position, input filtered_velocity, output ready);
endinterface

>>> sv/kfcv_apb_regs.sv
// APB configuration registers holding the process and measurement noise.
`timescale 1ns / 1ps

module kfcv_apb_regs import kfcv_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output kfcv_cfg_t                 cfg
);

  kfcv_reg_t reg_sel;

  // Registers sit on a four-byte pitch, so bit 2 of the address picks one.
  assign reg_sel = kfcv_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.process_noise     <= PROCESS_NOISE_RESET;
      cfg.measurement_noise <= MEASUREMENT_NOISE_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_PROCESS_NOISE:     cfg.process_noise     <= pwdata[CFG_WIDTH-1:0];
        REG_MEASUREMENT_NOISE: cfg.measurement_noise <= pwdata[CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_PROCESS_NOISE:     prdata = {1'b0, cfg.process_noise};
      REG_MEASUREMENT_NOISE: prdata = {1'b0, cfg.measurement_noise};
      default:               prdata = '0;
    endcase
  end

endmodule

>>> sv/kfcv_div.sv
// Restoring divider producing a saturated fixed-point gain, one quotient bit per cycle.
`timescale 1ns / 1ps

module kfcv_div import kfcv_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  cov_t                         num,
  input  logic [COV_WIDTH-1:0]         den,
  output logic signed [DATA_WIDTH-1:0] quot,
  output kfcv_unit_stat_t              stat
);

  localparam int NUM_W = COV_WIDTH + FRAC_BITS;
  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [DATA_WIDTH-1:0] CAP_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef enum logic [1:0] {
    D_IDLE,
    D_SETUP,
    D_RUN,
    D_FIN
  } dstate_t;

  dstate_t               state;
  logic                  done;
  logic [COV_WIDTH-1:0]  mag;
  logic                  neg;
  logic [COV_WIDTH-1:0]  dvsr;
  logic [COV_WIDTH-1:0]  rem;
  logic [DATA_WIDTH-1:0] work;
  logic [CNT_W-1:0]      cnt;
  logic                  ovf;

  logic [NUM_W-1:0]      numer;
  logic [NUM_W-1:0]      numer_hi;
  logic                  too_big;
  logic [COV_WIDTH:0]    trial;
  logic [COV_WIDTH:0]    diff;
  logic                  fits;
  logic [COV_WIDTH-1:0]  rem_next;
  logic [DATA_WIDTH-1:0] cap;
  logic [DATA_WIDTH-1:0] q_mag;

  // The numerator is the magnitude scaled by the fraction bits. Whatever lies above
  // the low DATA_WIDTH bits must divide to zero, or the quotient is out of range.
  assign numer    = {mag, {FRAC_BITS{1'b0}}};
  assign numer_hi = numer >> DATA_WIDTH;
  assign too_big  = numer_hi >= NUM_W'(dvsr);

  assign trial    = {rem, work[DATA_WIDTH-1]};
  assign diff     = trial - {1'b0, dvsr};
  assign fits     = trial >= {1'b0, dvsr};
  assign rem_next = fits ? diff[COV_WIDTH-1:0] : trial[COV_WIDTH-1:0];

  assign cap   = CAP_POS + DATA_WIDTH'(neg);
  assign q_mag = (ovf || (work > cap)) ? cap : work;

  assign stat.busy = (state != D_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        D_IDLE: begin
          done <= 1'b0;
          if (start) begin
            mag   <= num[COV_WIDTH-1] ? COV_WIDTH'(-num) : COV_WIDTH'(num);
            neg   <= num[COV_WIDTH-1];
            dvsr  <= den;
            state <= D_SETUP;
          end
        end
        D_SETUP: begin
          ovf  <= too_big;
          rem  <= numer_hi[COV_WIDTH-1:0];
          work <= numer[DATA_WIDTH-1:0];
          cnt  <= '0;
          state <= too_big ? D_FIN : D_RUN;
        end
        D_RUN: begin
          rem  <= rem_next;
          work <= {work[DATA_WIDTH-2:0], fits};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          quot  <= neg ? -q_mag : q_mag;
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

>>> sv/kfcv_mul.sv
// Sequential multiplier built from four half-width partial products, scaled and saturated.
`timescale 1ns / 1ps

module kfcv_mul import kfcv_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            wide,
  input  cov_t            a,
  input  cov_t            b,
  output cov_t            res,
  output kfcv_unit_stat_t stat
);

  localparam logic [COV_WIDTH-1:0] CAP_COV  = {1'b0, {(COV_WIDTH-1){1'b1}}};
  localparam logic [COV_WIDTH-1:0] CAP_DATA = COV_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic [2:0]           LAST_IDX = 3'd4;

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_FIN
  } mstate_t;

  mstate_t                state;
  logic                   done;
  logic [COV_WIDTH-1:0]   ma;
  logic [COV_WIDTH-1:0]   mb;
  logic                   neg;
  logic                   wide_r;
  logic [2:0]             idx;
  logic [COV_WIDTH-1:0]   pp;
  logic [1:0]             sh;
  logic [PROD_WIDTH-1:0]  acc;

  logic [HALF_WIDTH-1:0]  a_half;
  logic [HALF_WIDTH-1:0]  b_half;
  logic [PROD_WIDTH-1:0]  pp_placed;
  logic [PROD_WIDTH-1:0]  scaled;
  logic [COV_WIDTH-1:0]   cap;
  logic [COV_WIDTH-1:0]   r_mag;

  assign a_half = idx[1] ? ma[COV_WIDTH-1:HALF_WIDTH] : ma[HALF_WIDTH-1:0];
  assign b_half = idx[0] ? mb[COV_WIDTH-1:HALF_WIDTH] : mb[HALF_WIDTH-1:0];

  always_comb begin
    case (sh)
      2'd0:    pp_placed = PROD_WIDTH'(pp);
      2'd1:    pp_placed = PROD_WIDTH'(pp) << HALF_WIDTH;
      2'd2:    pp_placed = PROD_WIDTH'(pp) << COV_WIDTH;
      default: pp_placed = '0;
    endcase
  end

  // Truncation toward zero works on the magnitude; the sign goes back on at the end.
  assign scaled = acc >> FRAC_BITS;
  assign cap    = (wide_r ? CAP_COV : CAP_DATA) + COV_WIDTH'(neg);
  assign r_mag  = (scaled > PROD_WIDTH'(cap)) ? cap : scaled[COV_WIDTH-1:0];

  assign stat.busy = (state != M_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        M_IDLE: begin
          done <= 1'b0;
          if (start) begin
            ma     <= a[COV_WIDTH-1] ? COV_WIDTH'(-a) : COV_WIDTH'(a);
            mb     <= b[COV_WIDTH-1] ? COV_WIDTH'(-b) : COV_WIDTH'(b);
            neg    <= a[COV_WIDTH-1] ^ b[COV_WIDTH-1];
            wide_r <= wide;
            acc    <= '0;
            idx    <= '0;
            state  <= M_RUN;
          end
        end
        M_RUN: begin
          // Partial product for this step; the previous one is added in alongside.
          if (idx != LAST_IDX) begin
            pp <= a_half * b_half;
            sh <= {1'b0, idx[1]} + {1'b0, idx[0]};
          end
          if (idx != 3'd0) begin
            acc <= acc + pp_placed;
          end
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          res   <= neg ? -cov_t'(r_mag) : cov_t'(r_mag);
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

>>> sv/kalman_filter_const_velocity.sv
// Top level of the two-state constant-velocity Kalman filter with its update sequencer.
// Each measurement transfer runs one predict and one update of a position/velocity
// tracker and yields one transfer of the filtered position and velocity. The block
// takes one measurement at a time: meas.ready is high only while the sequencer is idle,
// and it returns to idle as the result is offered, so the next measurement can be
// accepted from then on. An item runs through predict and variance check, the two
// gain divisions in the shared restoring divider, which retires one quotient bit per
// cycle, and the five products of the update, which share one multiplier that builds
// each result from four half-width partial products. When the update is skipped the
// sequencer goes straight from the variance check to the hand-over. A finished result
// waits in an output register, so the next measurement can be taken while it is still
// pending; a further result is held back until that register has been emptied. All
// data are signed two's complement with FRAC_BITS fraction bits; covariances are 48
// bits wide. Every sum and product saturates rather than wraps. When the innovation
// variance (predicted position variance plus measurement noise) is zero or negative
// the update is skipped and the predicted state is kept. The noise registers are
// written over APB at byte addresses 0 (process noise) and 4 (measurement noise) and
// should only be changed while idle.
`timescale 1ns / 1ps

module kalman_filter_const_velocity import kfcv_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  kfcv_meas_if.sink                 meas,
  kfcv_est_if.source                est
);

  localparam int DE = DATA_WIDTH + 2;
  localparam int CE = COV_WIDTH + 4;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [DE-1:0]         dext_t;
  typedef logic signed [CE-1:0]         cext_t;

  localparam data_t DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam cov_t  COV_MAX  = {1'b0, {(COV_WIDTH-1){1'b1}}};
  localparam cov_t  COV_MIN  = {1'b1, {(COV_WIDTH-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED_A,
    ST_PRED_B,
    ST_CHECK,
    ST_K0_GO,
    ST_K0_WAIT,
    ST_K1_GO,
    ST_K1_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_DONE
  } state_t;

  // Order of the five products of the update step.
  typedef enum logic [2:0] {
    MS_POS,
    MS_VEL,
    MS_PP,
    MS_PV,
    MS_VV
  } mstep_t;

  // Saturation keeps the value when all bits above the sign agree with it.
  function automatic data_t sat_data(input dext_t v);
    if (v[DE-1:DATA_WIDTH-1] == '0 || v[DE-1:DATA_WIDTH-1] == '1) begin
      return v[DATA_WIDTH-1:0];
    end
    return v[DE-1] ? DATA_MIN : DATA_MAX;
  endfunction

  function automatic cov_t sat_cov(input cext_t v);
    if (v[CE-1:COV_WIDTH-1] == '0 || v[CE-1:COV_WIDTH-1] == '1) begin
      return v[COV_WIDTH-1:0];
    end
    return v[CE-1] ? COV_MIN : COV_MAX;
  endfunction

  kfcv_cfg_t cfg;

  state_t state;
  mstep_t mstep;

  // Filter state, cleared by reset.
  data_t pos;
  data_t vel;
  cov_t  cpp;
  cov_t  cpv;
  cov_t  cvv;

  // Working registers of one update.
  data_t                z;
  data_t                xp;
  data_t                y;
  cext_t                t_pp;
  cext_t                t_vv;
  cov_t                 p00;
  cov_t                 p01;
  cov_t                 p11;
  logic [COV_WIDTH-1:0] s_den;
  data_t                k0;
  data_t                k1;

  // Output register.
  logic  est_valid;
  data_t out_pos;
  data_t out_vel;

  cext_t           s_sum;
  logic            s_pos;
  logic            div_start;
  cov_t            div_num;
  data_t           div_quot;
  kfcv_unit_stat_t div_stat;
  logic            mul_start;
  logic            mul_wide;
  cov_t            mul_a;
  cov_t            mul_b;
  cov_t            mul_res;
  data_t           mul_dw;
  kfcv_unit_stat_t mul_stat;

  assign pready = 1'b1;

  kfcv_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Both gains share the innovation variance as divisor.
  assign div_start = (state == ST_K0_GO) || (state == ST_K1_GO);
  assign div_num   = (state == ST_K1_GO) ? p01 : p00;

  kfcv_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (s_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // Operand selection for the shared multiplier. The state products saturate to the data
  // width, the covariance products to the covariance width.
  always_comb begin
    mul_a    = cov_t'(k0);
    mul_b    = cov_t'(y);
    mul_wide = 1'b0;
    case (mstep)
      MS_POS: begin
        mul_a = cov_t'(k0);
        mul_b = cov_t'(y);
      end
      MS_VEL: begin
        mul_a = cov_t'(k1);
        mul_b = cov_t'(y);
      end
      MS_PP: begin
        mul_a    = cov_t'(k0);
        mul_b    = p00;
        mul_wide = 1'b1;
      end
      MS_PV: begin
        mul_a    = cov_t'(k0);
        mul_b    = p01;
        mul_wide = 1'b1;
      end
      MS_VV: begin
        mul_a    = cov_t'(k1);
        mul_b    = p01;
        mul_wide = 1'b1;
      end
      default: ;
    endcase
  end

  assign mul_start = (state == ST_MUL_GO);

  kfcv_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .wide  (mul_wide),
    .a     (mul_a),
    .b     (mul_b),
    .res   (mul_res),
    .stat  (mul_stat)
  );

  // A product capped at the data width always fits in its low bits.
  assign mul_dw = mul_res[DATA_WIDTH-1:0];

  // Innovation variance; the update only runs when it is strictly positive.
  assign s_sum = cext_t'(p00) + cext_t'({1'b0, cfg.measurement_noise});
  assign s_pos = !s_sum[CE-1] && (s_sum != '0);

  assign meas.ready            = (state == ST_IDLE);
  assign est.valid             = est_valid;
  assign est.filtered_position = out_pos;
  assign est.filtered_velocity = out_vel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mstep     <= MS_POS;
      est_valid <= 1'b0;
      pos       <= '0;
      vel       <= '0;
      cpp       <= '0;
      cpv       <= '0;
      cvv       <= '0;
    end else begin
      // In the hand-over state the output register is reloaded instead of emptied.
      if (est_valid && est.ready && (state != ST_DONE)) begin
        est_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (meas.valid) begin
            z     <= meas.measurement;
            state <= ST_PRED_A;
          end
        end
        ST_PRED_A: begin
          // Predict: position moves by one sample of velocity and the covariance grows.
          xp    <= sat_data(dext_t'(pos) + dext_t'(vel));
          t_pp  <= cext_t'(cpp) + (cext_t'(cpv) <<< 1);
          t_vv  <= cext_t'(cvv) + cext_t'({1'b0, cfg.process_noise});
          p01   <= sat_cov(cext_t'(cpv) + cext_t'(cvv));
          state <= ST_PRED_B;
        end
        ST_PRED_B: begin
          p00   <= sat_cov(t_pp + t_vv);
          p11   <= sat_cov(t_vv);
          y     <= sat_data(dext_t'(z) - dext_t'(xp));
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          s_den <= s_sum[COV_WIDTH-1:0];
          if (s_pos) begin
            state <= ST_K0_GO;
          end else begin
            // Degenerate innovation variance: keep the prediction as it stands.
            pos   <= xp;
            cpp   <= p00;
            cpv   <= p01;
            cvv   <= p11;
            state <= ST_DONE;
          end
        end
        ST_K0_GO: begin
          state <= ST_K0_WAIT;
        end
        ST_K0_WAIT: begin
          if (div_stat.done) begin
            k0    <= div_quot;
            state <= ST_K1_GO;
          end
        end
        ST_K1_GO: begin
          state <= ST_K1_WAIT;
        end
        ST_K1_WAIT: begin
          if (div_stat.done) begin
            k1    <= div_quot;
            mstep <= MS_POS;
            state <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: begin
          state <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mul_stat.done) begin
            state <= ST_MUL_GO;
            case (mstep)
              MS_POS: begin
                pos   <= sat_data(dext_t'(xp) + dext_t'(mul_dw));
                mstep <= MS_VEL;
              end
              MS_VEL: begin
                vel   <= sat_data(dext_t'(vel) + dext_t'(mul_dw));
                mstep <= MS_PP;
              end
              MS_PP: begin
                cpp   <= sat_cov(cext_t'(p00) - cext_t'(mul_res));
                mstep <= MS_PV;
              end
              MS_PV: begin
                cpv   <= sat_cov(cext_t'(p01) - cext_t'(mul_res));
                mstep <= MS_VV;
              end
              MS_VV: begin
                cvv   <= sat_cov(cext_t'(p11) - cext_t'(mul_res));
                state <= ST_DONE;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_DONE: begin
          // Hand the estimate over once the output register is free or being emptied.
          if (!est_valid || est.ready) begin
            est_valid <= 1'b1;
            out_pos   <= pos;
            out_vel   <= vel;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while still busy");

  a_mul_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while still busy");

  a_single_done: assert property (@(posedge clk) disable iff (rst)
    !(div_stat.done && mul_stat.done))
    else $error("divider and multiplier finished in the same cycle");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (meas.valid && meas.ready) |=> !meas.ready)
    else $error("measurement taken while an update was in progress");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(est.valid) |-> $past(state == ST_DONE))
    else $error("estimate offered without a completed update");
`endif

endmodule

>>> bench/tb.sv
// Self-checking testbench for the constant-velocity Kalman filter.
`timescale 1ns / 1ps

module tb import kfcv_pkg::*; ();

  localparam int DW = DEF_DATA_WIDTH;
  localparam int FB = DEF_FRAC_BITS;
  localparam int CW = COV_WIDTH;

  // Used to size the final quiet spell.
  localparam int LATENCY = 2 * DW + 52;

  localparam logic [CFG_WIDTH-1:0] NOISE_MAX = {CFG_WIDTH{1'b1}};
  localparam logic signed [DW-1:0] MEAS_MAX  = {1'b0, {(DW - 1){1'b1}}};
  localparam logic signed [DW-1:0] MEAS_MIN  = {1'b1, {(DW - 1){1'b0}}};

  typedef struct {
    logic signed [DW-1:0] position;
    logic signed [DW-1:0] velocity;
  } estimate_t;

  // The scoreboard carries its own copy of the filter state and noise settings. Every
  // accepted measurement is run through one predict and one update step straight away,
  // and the resulting estimate waits in order until the block offers its result.
  class estimate_scoreboard;
    longint    position;
    longint    velocity;
    longint    var_pos;
    longint    cov_pv;
    longint    var_vel;
    longint    proc_noise;
    longint    meas_noise;
    estimate_t expected_estimates[$];
    int        errors;
    int        checked;
    int        skipped_updates;

    function new();
      position   = 0;
      velocity   = 0;
      var_pos    = 0;
      cov_pv     = 0;
      var_vel    = 0;
      proc_noise = longint'(PROCESS_NOISE_RESET);
      meas_noise = longint'(MEASUREMENT_NOISE_RESET);
    endfunction

    static function longint clamp(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    static function longint unsigned magnitude_of(longint a);
      return (a < 0) ? -a : a;
    endfunction

    // Exact product scaled down by the fraction bits, truncated towards zero, saturated.
    static function longint scaled_product(longint a, longint b, int w);
      logic [127:0]     full;
      longint unsigned  cap;
      longint unsigned  res;
      bit               neg;
      neg  = (a < 0) != (b < 0);
      full = {64'd0, magnitude_of(a)} * {64'd0, magnitude_of(b)};
      full = full >> FB;
      cap  = (64'd1 << (w - 1)) - 64'd1 + 64'(neg);
      if (full > {64'd0, cap}) full = {64'd0, cap};
      res = full[63:0];
      return neg ? -longint'(res) : longint'(res);
    endfunction

    // Gain: n scaled up by the fraction bits over a positive d, truncated, saturated.
    static function longint scaled_quotient(longint n, longint d, int w);
      logic [127:0]     quo;
      longint unsigned  cap;
      longint unsigned  res;
      bit               neg;
      neg = n < 0;
      quo = ({64'd0, magnitude_of(n)} << FB) / {64'd0, d};
      cap = (64'd1 << (w - 1)) - 64'd1 + 64'(neg);
      if (quo > {64'd0, cap}) quo = {64'd0, cap};
      res = quo[63:0];
      return neg ? -longint'(res) : longint'(res);
    endfunction

    function void set_noise(kfcv_reg_t idx, logic [CFG_WIDTH-1:0] value);
      case (idx)
        REG_PROCESS_NOISE: begin
          proc_noise = longint'(value);
        end
        REG_MEASUREMENT_NOISE: begin
          meas_noise = longint'(value);
        end
        default: begin
        end
      endcase
    endfunction

    function void note_measurement(logic signed [DW-1:0] z);
      longint    pred_pos;
      longint    pred_vel;
      longint    p00;
      longint    p01;
      longint    p11;
      longint    innov_var;
      longint    gain_pos;
      longint    gain_vel;
      longint    innov;
      estimate_t est;
      pred_pos  = clamp(position + velocity, DW);
      pred_vel  = velocity;
      p00       = clamp(var_pos + 2 * cov_pv + var_vel + proc_noise, CW);
      p01       = clamp(cov_pv + var_vel, CW);
      p11       = clamp(var_vel + proc_noise, CW);
      innov_var = p00 + meas_noise;
      if (innov_var > 0) begin
        gain_pos = scaled_quotient(p00, innov_var, DW);
        gain_vel = scaled_quotient(p01, innov_var, DW);
        innov    = clamp(longint'(z) - pred_pos, DW);
        position = clamp(pred_pos + scaled_product(gain_pos, innov, DW), DW);
        velocity = clamp(pred_vel + scaled_product(gain_vel, innov, DW), DW);
        var_pos  = clamp(p00 - scaled_product(gain_pos, p00, CW), CW);
        cov_pv   = clamp(p01 - scaled_product(gain_pos, p01, CW), CW);
        var_vel  = clamp(p11 - scaled_product(gain_vel, p01, CW), CW);
      end else begin
        // No usable innovation variance: keep the prediction as it stands.
        position = pred_pos;
        velocity = pred_vel;
        var_pos  = p00;
        cov_pv   = p01;
        var_vel  = p11;
        skipped_updates++;
      end
      est.position = position[DW-1:0];
      est.velocity = velocity[DW-1:0];
      expected_estimates.push_back(est);
    endfunction

    function void check_estimate(logic signed [DW-1:0] pos, logic signed [DW-1:0] vel);
      estimate_t want;
      if (expected_estimates.size() == 0) begin
        $display("%0t: unexpected estimate transfer, position %0d velocity %0d",
                 $time, pos, vel);
        errors++;
        return;
      end
      want = expected_estimates.pop_front();
      checked++;
      if (pos !== want.position) begin
        $display("%0t: filtered_position expected %0d, got %0d", $time, want.position, pos);
        errors++;
      end
      if (vel !== want.velocity) begin
        $display("%0t: filtered_velocity expected %0d, got %0d", $time, want.velocity, vel);
        errors++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  kfcv_meas_if #(.DATA_WIDTH(DW)) meas_ch ();
  kfcv_est_if  #(.DATA_WIDTH(DW)) est_ch ();

  kalman_filter_const_velocity #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .meas   (meas_ch),
    .est    (est_ch)
  );

  estimate_scoreboard sb = new();

  // When set, neither side inserts gaps or stalls, so back-to-back transfers are exercised.
  bit quiet;
  int items_sent;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("%0t: timed out waiting for the filter", $time);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  // Register write in two phases. The select is left high so that a following write
  // can start at once; apply_setting ends the burst.
  task automatic write_register(input kfcv_reg_t idx, input logic [CFG_WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_WIDTH'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_noise(idx, value);
  endtask

  // Waits until every predicted estimate has been seen, with the measurement side idle.
  task automatic drain_estimates();
    meas_ch.valid <= 1'b0;
    while (sb.expected_estimates.size() != 0) @(posedge clk);
  endtask

  // Noise settings are only changed once the filter has nothing left in flight.
  task automatic apply_setting(input logic [CFG_WIDTH-1:0] q, input logic [CFG_WIDTH-1:0] r);
    drain_estimates();
    write_register(REG_PROCESS_NOISE, q);
    write_register(REG_MEASUREMENT_NOISE, r);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  // One measurement transfer. Valid stays high across back-to-back items and is only
  // dropped when a gap is drawn, so it is never lowered and raised in the same step.
  task automatic send_measurement(input logic signed [DW-1:0] z);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      meas_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    meas_ch.valid       <= 1'b1;
    meas_ch.measurement <= z;
    do @(posedge clk); while (!meas_ch.ready);
    sb.note_measurement(z);
    items_sent++;
  endtask

  // Most items follow a moving target with bounded sensor noise, which is what drives the
  // covariance towards a steady state. The rest are manoeuvres, jumps and wild samples.
  task automatic run_track(input int count);
    longint target;
    longint speed;
    longint noise;
    longint amp;
    int     kind;
    logic signed [DW-1:0] z;
    target = longint'(int'($urandom)) / 2;
    speed  = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
    amp    = longint'($urandom_range(0, 1 << 18));
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        z = $urandom;
      end else begin
        if (kind == 1) target = longint'(int'($urandom)) / 2;
        if (kind == 2) speed = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        target = estimate_scoreboard::clamp(target + speed, DW);
        // Bounce off the ends of the range rather than sit on the limit.
        if (target == longint'(MEAS_MAX) || target == longint'(MEAS_MIN)) speed = -speed;
        noise = longint'($urandom_range(0, 2 * amp)) - amp;
        z = DW'(estimate_scoreboard::clamp(target + noise, DW));
      end
      send_measurement(z);
    end
  endtask

  // Result side: a fresh stall is drawn for every estimate, and ready is held between
  // back-to-back transfers when no stall is drawn.
  initial begin
    int stall;
    est_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        est_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      est_ch.ready <= 1'b1;
      do @(posedge clk); while (!est_ch.valid);
      sb.check_estimate(est_ch.filtered_position, est_ch.filtered_velocity);
    end
  end

  initial begin
    logic [CFG_WIDTH-1:0] q;
    logic [CFG_WIDTH-1:0] r;
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    meas_ch.valid       <= 1'b0;
    meas_ch.measurement <= '0;
    quiet         = 1'b0;
    items_sent    = 0;
    settings_used = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // With both noises at zero and the covariance fresh from reset, the innovation
    // variance is zero, so the update must be skipped and the prediction kept.
    apply_setting('0, '0);
    send_measurement('0);
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);

    // Huge process noise against minimal measurement noise: the gain is close to one and
    // full-scale swings push the velocity and innovation into saturation.
    apply_setting(NOISE_MAX, 31'd1);
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    send_measurement(-32'sd1);
    send_measurement(32'sd1);
    send_measurement('0);

    // No process noise against the largest measurement noise: the gain all but vanishes.
    apply_setting('0, NOISE_MAX);
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    send_measurement(32'sd12345);
    send_measurement(-32'sd1);
    send_measurement('0);

    // Random part: a new noise setting for every phase, each phase ending with the
    // sender holding off until the filter has delivered everything.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          q = PROCESS_NOISE_RESET;
          r = MEASUREMENT_NOISE_RESET;
        end
        1: begin
          q = CFG_WIDTH'($urandom_range(0, 1 << 24));
          r = CFG_WIDTH'($urandom_range(1, 1 << 24));
        end
        3: begin
          q = CFG_WIDTH'($urandom_range(0, 255));
          r = NOISE_MAX;
        end
        4: begin
          q = CFG_WIDTH'($urandom_range(0, 1 << 20));
          r = 31'd1;
        end
        default: begin
          q = CFG_WIDTH'($urandom);
          r = CFG_WIDTH'($urandom);
        end
      endcase
      apply_setting(q, r);
      quiet = (ph == 2);
      run_track(125);
    end
    quiet = 1'b0;

    drain_estimates();
    repeat (2 * LATENCY) @(posedge clk);
    if (sb.expected_estimates.size() != 0) begin
      $display("%0t: %0d estimates never arrived", $time, sb.expected_estimates.size());
      sb.errors++;
    end
    $display("Sent %0d measurements under %0d noise settings; %0d estimates checked.",
             items_sent, settings_used, sb.checked);
    $display("Updates skipped for a non-positive innovation variance: %0d.",
             sb.skipped_updates);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
